@@ rtl/core/max_diagonal_sum_unit_macros.svh @@
// assertion macros for the max diagonal sum rtl, used by mds_back
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef MAX_DIAGONAL_SUM_UNIT_MACROS_SVH
`define MAX_DIAGONAL_SUM_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define MDS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MDS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/mds_pkg.sv @@
// package for the max diagonal sum unit: fixed widths, register codes, flag struct
// no dependencies
`timescale 1ns / 1ps

package mds_pkg;

  // fixed field widths
  localparam int unsigned SIZE_W  = 7;
  localparam int unsigned SUM_W   = 22;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  // saturation bounds of a line sum
  localparam int SUM_MAX = 2097151;
  localparam int SUM_MIN = -2097152;

  // reset values of the configuration registers
  localparam logic [SIZE_W-1:0]       SIZE_RESET  = 7'd1;
  localparam logic signed [SUM_W-1:0] FLOOR_RESET = -22'sd100;

  // register codes, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_MATRIX_SIZE = 1'b0,
    REG_MAX_FLOOR   = 1'b1
  } mds_reg_e;

  // classification of one element
  typedef struct packed {
    logic first;      // element (0,0), starts a matrix
    logic last_diag;  // closes its diagonal
    logic last_anti;  // closes its anti-diagonal
    logic last_elem;  // closes the matrix
  } mds_flags_t;

endpackage

@@ rtl/core/mds_front.sv @@
// front end: element counters, line index computation and classification
// depends on mds_pkg
`timescale 1ns / 1ps

module mds_front
  import mds_pkg::*;
#(
  parameter int unsigned MAX_SIZE   = 64,
  parameter int unsigned VALUE_BITS = 16,
  localparam int unsigned LINES     = 2 * MAX_SIZE - 1,
  localparam int unsigned LINE_W    = $clog2(LINES)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         size_wr_i,
  input  logic [SIZE_W-1:0]            matrix_size_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [VALUE_BITS-1:0] element_value_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output mds_flags_t                   flags_o,
  output logic [LINE_W-1:0]            diag_idx_o,
  output logic [LINE_W-1:0]            anti_idx_o,
  output logic signed [VALUE_BITS-1:0] value_o
);

  localparam int unsigned IDX_W = $clog2(MAX_SIZE);
  localparam int unsigned N_W   = $clog2(MAX_SIZE + 1);
  localparam int unsigned CMP_W = (N_W > SIZE_W) ? N_W : SIZE_W;

  logic [IDX_W-1:0] row_q, row_d;
  logic [IDX_W-1:0] col_q, col_d;
  logic [CMP_W-1:0] size_ext;
  logic [N_W-1:0]   side_len;
  logic [IDX_W-1:0] last_idx;
  logic             last_row, last_col, accept;

  // effective side length, clamped to 1..MAX_SIZE
  always_comb begin
    size_ext = CMP_W'(matrix_size_i);
    if (size_ext == '0) begin
      side_len = N_W'(1);
    end else if (size_ext > CMP_W'(MAX_SIZE)) begin
      side_len = N_W'(MAX_SIZE);
    end else begin
      side_len = N_W'(size_ext);
    end
    last_idx = IDX_W'(side_len - N_W'(1));
  end

  // classification of the current element
  assign last_row = (row_q == last_idx);
  assign last_col = (col_q == last_idx);

  always_comb begin
    flags_o.first     = (row_q == '0) && (col_q == '0);
    flags_o.last_diag = last_row || last_col;
    flags_o.last_anti = last_row || (col_q == '0);
    flags_o.last_elem = last_row && last_col;
  end

  // line indexes: diagonal r + n - 1 - c, anti-diagonal r + c
  assign diag_idx_o = LINE_W'(row_q) + LINE_W'(last_idx) - LINE_W'(col_q);
  assign anti_idx_o = LINE_W'(row_q) + LINE_W'(col_q);
  assign value_o    = element_value_i;

  // request handshake into the queue
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept;

  // row-major position
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (size_wr_i) begin
      row_d = '0;
      col_d = '0;
    end else if (accept) begin
      if (last_row && last_col) begin
        row_d = '0;
        col_d = '0;
      end else if (last_col) begin
        row_d = row_q + IDX_W'(1);
        col_d = '0;
      end else begin
        col_d = col_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

@@ rtl/core/mds_queue.sv @@
// two-entry queue between front end and back end
// depends on nothing but the timescale
`timescale 1ns / 1ps

module mds_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

@@ rtl/core/mds_back.sv @@
// back end: line sum memories, saturating accumulate, running max, result register
// depends on mds_pkg and max_diagonal_sum_unit_macros.svh
`timescale 1ns / 1ps
`include "max_diagonal_sum_unit_macros.svh"

module mds_back
  import mds_pkg::*;
#(
  parameter int unsigned MAX_SIZE   = 64,
  parameter int unsigned VALUE_BITS = 16,
  localparam int unsigned LINES     = 2 * MAX_SIZE - 1,
  localparam int unsigned LINE_W    = $clog2(LINES)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  mds_flags_t                   q_flags_i,
  input  logic [LINE_W-1:0]            q_diag_i,
  input  logic [LINE_W-1:0]            q_anti_i,
  input  logic signed [VALUE_BITS-1:0] q_value_i,
  output logic                         pop_o,
  input  logic signed [SUM_W-1:0]      floor_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [SUM_W-1:0]      max_sum_o
);

  localparam int unsigned SW = ((VALUE_BITS > SUM_W) ? VALUE_BITS : SUM_W) + 1;
  localparam logic signed [SW-1:0] SAT_HI = SW'(SUM_MAX);
  localparam logic signed [SW-1:0] SAT_LO = SW'(SUM_MIN);

  logic signed [SUM_W-1:0] diag_mem [LINES];
  logic signed [SUM_W-1:0] anti_mem [LINES];
  logic signed [SUM_W-1:0] diag_rd_q, anti_rd_q;
  logic [LINES-1:0]        diag_vld_q, anti_vld_q;

  logic                         adv;
  logic                         s2_valid_q;
  mds_flags_t                   s2_flags_q;
  logic [LINE_W-1:0]            s2_diag_q, s2_anti_q;
  logic signed [VALUE_BITS-1:0] s2_value_q;

  logic                    s3_valid_q;
  mds_flags_t              s3_flags_q;
  logic [LINE_W-1:0]       s3_diag_q, s3_anti_q;
  logic signed [SUM_W-1:0] s3_sd_q, s3_sa_q;

  logic signed [SUM_W-1:0] rm_q;
  logic                    out_valid_q;
  logic signed [SUM_W-1:0] max_sum_q;

  logic signed [SUM_W-1:0] old_d, old_a, sum_d, sum_a;
  logic signed [SW-1:0]    val_x, raw_d, raw_a;
  logic signed [SUM_W-1:0] base, max1, max2;

  // whole back pipeline moves when the result register can take a value
  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && q_valid_i;

  // diagonal sum memory, registered read at pop, write from stage two
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      diag_rd_q <= diag_mem[q_diag_i];
    end
    if (adv && s2_valid_q) begin
      diag_mem[s2_diag_q] <= sum_d;
    end
  end

  // anti-diagonal sum memory
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      anti_rd_q <= anti_mem[q_anti_i];
    end
    if (adv && s2_valid_q) begin
      anti_mem[s2_anti_q] <= sum_a;
    end
  end

  // per-line valid bits, cleared at once by the first element of a matrix
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diag_vld_q <= '0;
      anti_vld_q <= '0;
    end else if (adv && s2_valid_q) begin
      if (s2_flags_q.first) begin
        diag_vld_q <= LINES'(1) << s2_diag_q;
        anti_vld_q <= LINES'(1) << s2_anti_q;
      end else begin
        diag_vld_q[s2_diag_q] <= 1'b1;
        anti_vld_q[s2_anti_q] <= 1'b1;
      end
    end
  end

  // stage two: old value with bypass of the write just done, then saturating add
  always_comb begin
    if (s2_flags_q.first || !diag_vld_q[s2_diag_q]) begin
      old_d = '0;
    end else if (s3_valid_q && (s3_diag_q == s2_diag_q)) begin
      old_d = s3_sd_q;
    end else begin
      old_d = diag_rd_q;
    end
    if (s2_flags_q.first || !anti_vld_q[s2_anti_q]) begin
      old_a = '0;
    end else if (s3_valid_q && (s3_anti_q == s2_anti_q)) begin
      old_a = s3_sa_q;
    end else begin
      old_a = anti_rd_q;
    end

    val_x = {{(SW-VALUE_BITS){s2_value_q[VALUE_BITS-1]}}, s2_value_q};
    raw_d = {{(SW-SUM_W){old_d[SUM_W-1]}}, old_d} + val_x;
    raw_a = {{(SW-SUM_W){old_a[SUM_W-1]}}, old_a} + val_x;

    if (raw_d > SAT_HI) begin
      sum_d = SAT_HI[SUM_W-1:0];
    end else if (raw_d < SAT_LO) begin
      sum_d = SAT_LO[SUM_W-1:0];
    end else begin
      sum_d = raw_d[SUM_W-1:0];
    end
    if (raw_a > SAT_HI) begin
      sum_a = SAT_HI[SUM_W-1:0];
    end else if (raw_a < SAT_LO) begin
      sum_a = SAT_LO[SUM_W-1:0];
    end else begin
      sum_a = raw_a[SUM_W-1:0];
    end
  end

  // stage three: running max over the lines that close here
  always_comb begin
    base = s3_flags_q.first ? floor_i : rm_q;
    max1 = (s3_flags_q.last_diag && (s3_sd_q > base)) ? s3_sd_q : base;
    max2 = (s3_flags_q.last_anti && (s3_sa_q > max1)) ? s3_sa_q : max1;
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s2_flags_q <= q_flags_i;
      s2_diag_q  <= q_diag_i;
      s2_anti_q  <= q_anti_i;
      s2_value_q <= q_value_i;
    end
    if (adv && s2_valid_q) begin
      s3_flags_q <= s2_flags_q;
      s3_diag_q  <= s2_diag_q;
      s3_anti_q  <= s2_anti_q;
      s3_sd_q    <= sum_d;
      s3_sa_q    <= sum_a;
    end
    if (adv && s3_valid_q && s3_flags_q.last_elem) begin
      max_sum_q <= max2;
    end
  end

  // pipeline control, running max and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      rm_q        <= FLOOR_RESET;
    end else if (adv) begin
      s2_valid_q  <= q_valid_i;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q && s3_flags_q.last_elem;
      if (s3_valid_q) begin
        rm_q <= max2;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign max_sum_o   = max_sum_q;

  `MDS_ASSERT_NXT(a_last_gives_result, adv && s3_valid_q && s3_flags_q.last_elem, out_valid_q, "last element did not produce a result")
  `MDS_ASSERT_IMP(a_first_sums_agree, s3_valid_q && s3_flags_q.first, s3_sd_q == s3_sa_q, "first element sums differ, stale line value used")
  `MDS_ASSERT_NXT(a_frozen_on_stall, !adv, $stable(rm_q) && $stable(s2_valid_q) && $stable(s3_valid_q), "back pipeline moved while the result was stalled")

endmodule

@@ rtl/core/max_diagonal_sum_unit.sv @@
// top level of the max diagonal sum unit: configuration registers and the
// front end, queue and back end; depends on mds_pkg, mds_front, mds_queue, mds_back
`timescale 1ns / 1ps

// Usage:
// Elements of an n by n signed matrix enter in row-major order on the input
// channel (element_value_i, in_valid_i, in_stall_o), one request per element.
// After the last element of a matrix one result leaves on the output channel
// (max_sum_o, out_valid_o, out_stall_i): the largest diagonal or anti-diagonal
// sum, never below the floor register. Line sums saturate to 22 bits.
// The APB port holds matrix_size (address 0) and max_floor (address 4); write
// them only while the block is idle. Writing matrix_size restarts the matrix.
// Throughput is one element per cycle while in_stall_o is low. With no stall the
// result is valid once the element has passed the queue, the registered line sum
// memory read and saturating add, and the running max into the result register.
// Reset clears the queue, the pipeline and the per-line valid bits; the size
// returns to 1 and the floor to -100. While out_stall_i holds a result, the
// back pipeline freezes, the two-entry queue fills and in_stall_o rises.
module max_diagonal_sum_unit
  import mds_pkg::*;
#(
  parameter int unsigned MAX_SIZE   = 64,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_W-1:0]            paddr,
  input  logic [DATA_W-1:0]            pwdata,
  output logic [DATA_W-1:0]            prdata,
  output logic                         pready,
  input  logic signed [VALUE_BITS-1:0] element_value_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  output logic signed [SUM_W-1:0]      max_sum_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i
);

  localparam int unsigned LINES  = 2 * MAX_SIZE - 1;
  localparam int unsigned LINE_W = $clog2(LINES);
  localparam int unsigned FLAG_W = $bits(mds_flags_t);
  localparam int unsigned QW     = FLAG_W + 2 * LINE_W + VALUE_BITS;

  logic [SIZE_W-1:0]       size_q;
  logic signed [SUM_W-1:0] floor_q;
  logic                    cfg_wr, size_wr;
  mds_reg_e                reg_sel;

  logic                         push, q_full, q_valid, pop;
  mds_flags_t                   f_flags, q_flags;
  logic [LINE_W-1:0]            f_diag, f_anti, q_diag, q_anti;
  logic signed [VALUE_BITS-1:0] f_value, q_value;
  logic [QW-1:0]                q_wdata, q_rdata;

  // configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = mds_reg_e'(paddr[2]);
  assign size_wr = cfg_wr && (reg_sel == REG_MATRIX_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= SIZE_RESET;
      floor_q <= FLOOR_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_MATRIX_SIZE: size_q  <= pwdata[SIZE_W-1:0];
        REG_MAX_FLOOR:   floor_q <= pwdata[SUM_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_sel)
      REG_MATRIX_SIZE: prdata = DATA_W'(size_q);
      REG_MAX_FLOOR:   prdata = {{(DATA_W-SUM_W){floor_q[SUM_W-1]}}, floor_q};
      default:         prdata = '0;
    endcase
  end

  mds_front #(
    .MAX_SIZE   (MAX_SIZE),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .size_wr_i       (size_wr),
    .matrix_size_i   (size_q),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .element_value_i (element_value_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .flags_o         (f_flags),
    .diag_idx_o      (f_diag),
    .anti_idx_o      (f_anti),
    .value_o         (f_value)
  );

  // pack and unpack the queue entry
  assign q_wdata = {f_flags, f_diag, f_anti, f_value};
  assign {q_flags, q_diag, q_anti, q_value} = q_rdata;

  mds_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  mds_back #(
    .MAX_SIZE   (MAX_SIZE),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_flags_i   (q_flags),
    .q_diag_i    (q_diag),
    .q_anti_i    (q_anti),
    .q_value_i   (q_value),
    .pop_o       (pop),
    .floor_i     (floor_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .max_sum_o   (max_sum_o)
  );

endmodule

@@ verif/max_diagonal_sum_unit_tb.sv @@
// testbench for max_diagonal_sum_unit: streams square matrices over the element channel,
// predicts the largest diagonal sum of each and checks every result in order
// depends on mds_pkg and the max_diagonal_sum_unit rtl
`timescale 1ns / 1ps

module max_diagonal_sum_unit_tb
  import mds_pkg::*;
();

  localparam int MAX_SIZE     = 64;
  localparam int VALUE_BITS   = 16;
  localparam int LINE_COUNT   = 2 * MAX_SIZE - 1;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1380;
  localparam int PRINT_LIMIT  = 50;

  localparam logic signed [VALUE_BITS-1:0] ELEM_MAX = 16'sh7FFF;
  localparam logic signed [VALUE_BITS-1:0] ELEM_MIN = 16'sh8000;

  // idle styles for both channels
  localparam int IDLE_NONE  = 0;
  localparam int IDLE_LIGHT = 1;
  localparam int IDLE_HEAVY = 2;

  // element value styles
  localparam int VAL_FULL     = 0;
  localparam int VAL_SMALL    = 1;
  localparam int VAL_EXTREME  = 2;
  localparam int VAL_NEGATIVE = 3;

  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         psel            = 1'b0;
  logic                         penable         = 1'b0;
  logic                         pwrite          = 1'b0;
  logic [ADDR_W-1:0]            paddr           = '0;
  logic [DATA_W-1:0]            pwdata          = '0;
  logic [DATA_W-1:0]            prdata;
  logic                         pready;
  logic signed [VALUE_BITS-1:0] element_value_i = '0;
  logic                         in_valid_i      = 1'b0;
  logic                         in_stall_o;
  logic signed [SUM_W-1:0]      max_sum_o;
  logic                         out_valid_o;
  logic                         out_stall_i     = 1'b0;

  // predictor state: configuration, line sums, position and running maximum
  logic [SIZE_W-1:0]       size_reg;
  logic signed [SUM_W-1:0] floor_reg;
  int                      diag_line_sum[LINE_COUNT];
  int                      anti_line_sum[LINE_COUNT];
  int                      row_pos;
  int                      col_pos;
  int                      best_sum;

  logic signed [SUM_W-1:0] expected_max_q[$];
  logic signed [SUM_W-1:0] want_sum;

  int feed_idle_mode  = IDLE_NONE;
  int drain_stall_mode = IDLE_NONE;
  int stall_left      = 0;
  int error_count     = 0;
  int elements_sent   = 0;
  int results_seen    = 0;

  max_diagonal_sum_unit #(
    .MAX_SIZE  (MAX_SIZE),
    .VALUE_BITS(VALUE_BITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .element_value_i(element_value_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .max_sum_o      (max_sum_o),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // gap length: mostly short, a few long
  function automatic int idle_length(input int mode);
    int pick;
    pick = $urandom_range(0, 99);
    if (mode == IDLE_NONE) return 0;
    if (mode == IDLE_LIGHT) begin
      if (pick < 80) return 0;
      if (pick < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 24);
    end
    if (pick < 40) return 0;
    if (pick < 80) return $urandom_range(1, 4);
    return $urandom_range(8, 30);
  endfunction

  function automatic int clamp_sum(input longint raw);
    if (raw > SUM_MAX) return SUM_MAX;
    if (raw < SUM_MIN) return SUM_MIN;
    return int'(raw);
  endfunction

  // one element in; returns 1 when it closes the matrix, with the expected maximum
  function automatic bit predict_max_sum(input logic signed [VALUE_BITS-1:0] value,
                                         output logic signed [SUM_W-1:0] max_out);
    int n;
    int r;
    int c;
    int d;
    int a;
    int v;
    n = (size_reg == 0) ? 1 : (size_reg > MAX_SIZE) ? MAX_SIZE : int'(size_reg);
    r = row_pos;
    c = col_pos;
    v = int'(value);
    if (r >= n || c >= n) begin
      r = 0;
      c = 0;
    end
    // first element clears all lines and reloads the floor
    if (r == 0 && c == 0) begin
      foreach (diag_line_sum[i]) begin
        diag_line_sum[i] = 0;
        anti_line_sum[i] = 0;
      end
      best_sum = int'(floor_reg);
    end
    d = (r + n - 1 - c) % LINE_COUNT;
    a = (r + c) % LINE_COUNT;
    diag_line_sum[d] = clamp_sum(longint'(diag_line_sum[d]) + v);
    anti_line_sum[a] = clamp_sum(longint'(anti_line_sum[a]) + v);
    // a diagonal ends on the bottom row or right column
    if ((r == n - 1 || c == n - 1) && diag_line_sum[d] > best_sum) best_sum = diag_line_sum[d];
    // an anti-diagonal ends on the bottom row or left column
    if ((r == n - 1 || c == 0) && anti_line_sum[a] > best_sum) best_sum = anti_line_sum[a];
    max_out = SUM_W'(best_sum);
    if (r == n - 1 && c == n - 1) begin
      row_pos = 0;
      col_pos = 0;
      return 1'b1;
    end
    if (c == n - 1) begin
      row_pos = r + 1;
      col_pos = 0;
    end else begin
      row_pos = r;
      col_pos = c + 1;
    end
    return 1'b0;
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] random_element(input int style);
    int pick;
    pick = $urandom_range(0, 2);
    case (style)
      VAL_SMALL:    return VALUE_BITS'(int'($urandom_range(0, 100)) - 50);
      VAL_EXTREME: begin
        if (pick == 0) return ELEM_MAX;
        if (pick == 1) return ELEM_MIN;
        return VALUE_BITS'($urandom);
      end
      VAL_NEGATIVE: return VALUE_BITS'(-int'($urandom_range(0, 32768)));
      default:      return VALUE_BITS'($urandom);
    endcase
  endfunction

  function automatic int random_floor();
    logic signed [SUM_W-1:0] raw;
    int pick;
    pick = $urandom_range(0, 9);
    raw = SUM_W'($urandom);
    if (pick < 5) return int'($urandom_range(0, 600)) - 300;
    if (pick < 7) return int'(raw);
    if (pick == 7) return SUM_MIN;
    if (pick == 8) return SUM_MAX;
    return -100;
  endfunction

  // apb write: setup then access; unused upper data bits carry noise
  task automatic write_reg(input mds_reg_e reg_sel, input int value);
    logic [DATA_W-1:0] word;
    word = $urandom;
    if (reg_sel == REG_MATRIX_SIZE) word[SIZE_W-1:0] = value[SIZE_W-1:0];
    else word[SUM_W-1:0] = value[SUM_W-1:0];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == REG_MATRIX_SIZE) begin
      size_reg = word[SIZE_W-1:0];
      row_pos  = 0;
      col_pos  = 0;
    end else begin
      floor_reg = word[SUM_W-1:0];
    end
  endtask

  // one element request; valid stays high across back-to-back requests
  task automatic send_element(input logic signed [VALUE_BITS-1:0] value);
    int gap;
    logic signed [SUM_W-1:0] result;
    gap = idle_length(feed_idle_mode);
    if (gap > 0) begin
      in_valid_i      <= 1'b0;
      element_value_i <= VALUE_BITS'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    element_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    elements_sent++;
    if (predict_max_sum(value, result)) expected_max_q.push_back(result);
  endtask

  // wait for every pending result, then let the element pipeline empty
  task automatic drain_pipeline();
    int saved_mode;
    in_valid_i <= 1'b0;
    while (expected_max_q.size() != 0) @(posedge clk_i);
    saved_mode       = drain_stall_mode;
    drain_stall_mode = IDLE_NONE;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    drain_stall_mode = saved_mode;
  endtask

  task automatic send_matrix(input int n, input int style);
    repeat (n * n) send_element(random_element(style));
  endtask

  // reset values: size 1, floor -100
  task automatic test_reset_values();
    send_element(16'sd5);
    send_element(ELEM_MIN);
    send_element(ELEM_MAX);
  endtask

  // size 0 behaves as size 1
  task automatic test_size_zero();
    drain_pipeline();
    write_reg(REG_MATRIX_SIZE, 0);
    send_element(-16'sd7);
    send_element(ELEM_MAX);
  endtask

  task automatic test_element_extremes();
    drain_pipeline();
    write_reg(REG_MAX_FLOOR, SUM_MIN);
    write_reg(REG_MATRIX_SIZE, 2);
    send_element(ELEM_MAX);
    send_element(ELEM_MIN);
    send_element(-16'sd1);
    send_element(16'sd0);
  endtask

  task automatic test_floor_extremes();
    drain_pipeline();
    write_reg(REG_MAX_FLOOR, SUM_MAX);
    write_reg(REG_MATRIX_SIZE, 1);
    send_element(ELEM_MAX);
    drain_pipeline();
    write_reg(REG_MAX_FLOOR, SUM_MIN);
    send_element(ELEM_MIN);
  endtask

  // rewriting the size abandons the partial matrix
  task automatic test_size_rewrite();
    drain_pipeline();
    write_reg(REG_MAX_FLOOR, -100);
    write_reg(REG_MATRIX_SIZE, 2);
    send_element(random_element(VAL_FULL));
    send_element(random_element(VAL_FULL));
    drain_pipeline();
    write_reg(REG_MATRIX_SIZE, 2);
    send_matrix(2, VAL_FULL);
  endtask

  // a floor written mid-matrix only applies from the next matrix
  task automatic test_floor_mid_matrix();
    drain_pipeline();
    write_reg(REG_MAX_FLOOR, 50);
    write_reg(REG_MATRIX_SIZE, 2);
    send_element(-16'sd3);
    send_element(-16'sd4);
    drain_pipeline();
    write_reg(REG_MAX_FLOOR, -2000);
    send_element(-16'sd5);
    send_element(-16'sd6);
    send_matrix(2, VAL_SMALL);
  endtask

  // first rows at the largest size and past a size above the maximum, left unfinished
  task automatic test_largest_size();
    drain_pipeline();
    feed_idle_mode   = IDLE_LIGHT;
    drain_stall_mode = IDLE_LIGHT;
    write_reg(REG_MAX_FLOOR, SUM_MIN);
    write_reg(REG_MATRIX_SIZE, MAX_SIZE);
    repeat (2 * MAX_SIZE) send_element(ELEM_MAX);
    drain_pipeline();
    write_reg(REG_MATRIX_SIZE, 127);
    repeat (MAX_SIZE + 3) send_element(ELEM_MIN);
  endtask

  // random phases: new size and sometimes a new floor, a few matrices, sometimes one cut short
  task automatic test_random_matrices();
    int stop_at;
    int n;
    int side;
    int pick;
    int style;
    int matrices;
    stop_at = elements_sent + RANDOM_ITEMS;
    while (elements_sent < stop_at) begin
      drain_pipeline();
      feed_idle_mode   = $urandom_range(IDLE_NONE, IDLE_HEAVY);
      drain_stall_mode = $urandom_range(IDLE_NONE, IDLE_HEAVY);
      pick = $urandom_range(0, 99);
      if (pick < 70) n = $urandom_range(1, 6);
      else if (pick < 90) n = $urandom_range(7, 16);
      else if (pick < 94) n = 0;
      else n = $urandom_range(17, 32);
      // keep the phase within the remaining element budget
      while (n > 1 && n * n > stop_at - elements_sent) n--;
      side = (n == 0) ? 1 : n;
      write_reg(REG_MATRIX_SIZE, n);
      if ($urandom_range(0, 1) == 1) write_reg(REG_MAX_FLOOR, random_floor());
      matrices = $urandom_range(1, 4);
      while (matrices > 1 && matrices * side * side > stop_at - elements_sent) matrices--;
      repeat (matrices) begin
        style = $urandom_range(VAL_FULL, VAL_NEGATIVE);
        send_matrix(side, style);
      end
      // broken sequence left for the next size write to abandon
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, side * side)) send_element(random_element(VAL_FULL));
    end
  endtask

  // output stall: random runs, none at all in quiet mode
  always @(posedge clk_i) begin
    if (drain_stall_mode == IDLE_NONE) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < (drain_stall_mode == IDLE_HEAVY ? 45 : 15));
      stall_left = idle_length(drain_stall_mode);
    end
  end

  // compare each accepted result with the oldest expected maximum
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (expected_max_q.size() == 0) begin
        error_count++;
        if (error_count <= PRINT_LIMIT)
          $display("%0t: result with none pending, expected none, actual max_sum %0d",
                   $time, max_sum_o);
      end else begin
        want_sum = expected_max_q.pop_front();
        results_seen++;
        if (max_sum_o !== want_sum) begin
          error_count++;
          if (error_count <= PRINT_LIMIT)
            $display("%0t: max_sum mismatch, expected %0d, actual %0d",
                     $time, want_sum, max_sum_o);
        end
      end
    end
  end

  // main sequence
  initial begin
    size_reg  = SIZE_RESET;
    floor_reg = FLOOR_RESET;
    foreach (diag_line_sum[i]) begin
      diag_line_sum[i] = 0;
      anti_line_sum[i] = 0;
    end
    row_pos  = 0;
    col_pos  = 0;
    best_sum = int'(FLOOR_RESET);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_size_zero();
    test_element_extremes();
    test_floor_extremes();
    test_size_rewrite();
    test_floor_mid_matrix();
    test_largest_size();
    test_random_matrices();
    drain_pipeline();
    $display("covered %0d elements and %0d matrix results, sizes 0 through 127,",
             elements_sent, results_seen);
    $display("both floor extremes, mid-matrix register writes and random stalls on both sides");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("timeout with %0d results still pending", expected_max_q.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
